FILE: src/wsfr_pkg.sv
// Shared types and constants for the WebSocket frame receiver.
package wsfr_pkg;

    // Widest frame length the receiver takes before closing (16..64)
    localparam int LENGTH_BITS = 64;

    // Length bits below 32 that a legal length may use
    localparam logic [31:0] LEN_FIT_MASK = (LENGTH_BITS >= 32) ? 32'hFFFF_FFFF
                                         : 32'((64'd1 << LENGTH_BITS) - 64'd1);

    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'(1024 * 1024 * 1024);

    // Opcodes
    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;
    localparam logic [3:0] OP_LAST_DATA = 4'h7;

    // 7-bit length escapes
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;

    // Close codes
    localparam logic [15:0] CODE_NORMAL = 16'd1000;
    localparam logic [15:0] CODE_PROTO  = 16'd1002;
    localparam logic [15:0] CODE_BIG    = 16'd1009;

    // Result kinds
    localparam logic [2:0] KIND_TEXT   = 3'd0;
    localparam logic [2:0] KIND_BINARY = 3'd1;
    localparam logic [2:0] KIND_CTRL   = 3'd2;
    localparam logic [2:0] KIND_PING   = 3'd3;
    localparam logic [2:0] KIND_CLOSE  = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic        has_data;
        logic [7:0]  payload_byte;
        logic        last;
        logic [3:0]  frame_opcode;
        logic [15:0] close_code;
    } wsfr_result_t;

    // Input register contents handed to the parser
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } wsfr_stage_t;

endpackage

FILE: src/wsfr_if.sv
// Valid/ready channel interfaces for the byte stream and the result stream.
interface wsfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsfr_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic        has_data;
    logic [7:0]  payload_byte;
    logic        last;
    logic [3:0]  frame_opcode;
    logic [15:0] close_code;

    modport source (output valid, output kind, output has_data, output payload_byte,
                    output last, output frame_opcode, output close_code, input ready);
    modport sink (input valid, input kind, input has_data, input payload_byte,
                  input last, input frame_opcode, input close_code, output ready);
endinterface

FILE: src/wsfr_in_stage.sv
// Input register: holds one received byte until the parser takes it.
module wsfr_in_stage
    import wsfr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    wsfr_byte_if.sink    rx,
    input  logic         pop,
    output wsfr_stage_t  stage
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    // Accept a new request whenever the slot is empty or being drained
    assign rx.ready = !valid_reg || pop;
    assign take     = rx.valid && rx.ready;

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= rx.rx_byte;
        end
    end

    assign stage.valid   = valid_reg;
    assign stage.rx_byte = byte_reg;

endmodule

FILE: src/wsfr_parser.sv
// Frame parser: header, length, mask key and unmasking state, one byte per cycle while the result register is free.
module wsfr_parser
    import wsfr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         max_payload_we,
    input  logic [31:0]  max_payload_wdata,
    input  wsfr_stage_t  stage,
    input  logic         out_free,
    output logic         pop,
    output logic         res_valid,
    output wsfr_result_t res
);

    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_MASK = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;

    logic [31:0] max_payload_reg;
    logic [2:0]  phase_reg,        phase_next;
    logic        final_reg,        final_next;
    logic [3:0]  msg_op_reg,       msg_op_next;
    logic        binary_reg,       binary_next;
    logic [3:0]  len_count_reg,    len_count_next;
    logic [31:0] remaining_reg,    remaining_next;
    logic        len_high_reg,     len_high_next;
    logic [31:0] mask_key_reg,     mask_key_next;
    logic [1:0]  mask_idx_reg,     mask_idx_next;
    logic [15:0] peer_reason_reg,  peer_reason_next;
    logic [1:0]  reason_seen_reg,  reason_seen_next;
    logic        closed_reg,       closed_next;

    logic [7:0]  b;
    logic [31:0] len_val;
    logic        len_high;
    logic        len_check;
    logic        too_big;
    logic        di_go;
    logic        di_has;
    logic [7:0]  di_byte;
    logic        di_end;
    logic        di_last;
    logic [7:0]  key_byte;

    assign pop = stage.valid && out_free;
    assign b   = stage.rx_byte;

    // Current mask key byte, most significant first
    always_comb
    begin
        case (mask_idx_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
    end

    // Next state and result for the byte in the input register
    always_comb
    begin
        phase_next       = phase_reg;
        final_next       = final_reg;
        msg_op_next      = msg_op_reg;
        binary_next      = binary_reg;
        len_count_next   = len_count_reg;
        remaining_next   = remaining_reg;
        len_high_next    = len_high_reg;
        mask_key_next    = mask_key_reg;
        mask_idx_next    = mask_idx_reg;
        peer_reason_next = peer_reason_reg;
        reason_seen_next = reason_seen_reg;
        closed_next      = closed_reg;

        res_valid        = 1'b0;
        res.kind         = KIND_TEXT;
        res.has_data     = 1'b0;
        res.payload_byte = 8'd0;
        res.last         = 1'b0;
        res.frame_opcode = msg_op_reg;
        res.close_code   = 16'd0;

        len_val   = 32'd0;
        len_high  = 1'b0;
        len_check = 1'b0;
        di_go     = 1'b0;
        di_has    = 1'b0;
        di_byte   = 8'd0;
        di_end    = 1'b0;

        if (pop && !closed_reg)
        begin
            case (phase_reg)
                PH_HDR0:
                begin
                    final_next = b[7];
                    if (b[3:0] != OP_CONT)
                    begin
                        msg_op_next      = b[3:0];
                        binary_next      = (b[3:0] != OP_TEXT);
                        peer_reason_next = 16'd0;
                        reason_seen_next = 2'd0;
                    end
                    phase_next = PH_HDR1;
                end
                PH_HDR1:
                begin
                    if (!b[7])
                    begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_CLOSE;
                        res.last       = 1'b1;
                        res.close_code = CODE_PROTO;
                        closed_next    = 1'b1;
                    end
                    else if (b[6:0] == LEN7_EXT16)
                    begin
                        remaining_next = 32'd0;
                        len_high_next  = 1'b0;
                        len_count_next = EXT16_BYTES;
                        phase_next     = PH_EXT;
                    end
                    else if (b[6:0] == LEN7_EXT64)
                    begin
                        remaining_next = 32'd0;
                        len_high_next  = 1'b0;
                        len_count_next = EXT64_BYTES;
                        phase_next     = PH_EXT;
                    end
                    else
                    begin
                        len_count_next = 4'd0;
                        len_val        = {25'd0, b[6:0]};
                        len_check      = 1'b1;
                    end
                end
                PH_EXT:
                begin
                    // Keep the low 32 bits; anything shifted out past them is sticky
                    len_val        = {remaining_reg[23:0], b};
                    len_high       = len_high_reg || (remaining_reg[31:24] != 8'd0);
                    remaining_next = len_val;
                    len_high_next  = len_high;
                    if (len_count_reg != 4'd0)
                    begin
                        len_count_next = len_count_reg - 4'd1;
                    end
                    if (len_count_reg <= 4'd1)
                    begin
                        len_check = 1'b1;
                    end
                end
                PH_MASK:
                begin
                    mask_key_next = {mask_key_reg[23:0], b};
                    mask_idx_next = mask_idx_reg + 2'd1;
                    if (mask_idx_reg == 2'd3)
                    begin
                        if (remaining_reg == 32'd0)
                        begin
                            phase_next = PH_HDR0;
                            di_go      = 1'b1;
                            di_end     = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    mask_idx_next  = mask_idx_reg + 2'd1;
                    remaining_next = remaining_reg - 32'd1;
                    di_go          = 1'b1;
                    di_has         = 1'b1;
                    di_byte        = b ^ key_byte;
                    di_end         = (remaining_reg == 32'd1);
                    if (di_end)
                    begin
                        phase_next = PH_HDR0;
                    end
                end
                default:
                begin
                    phase_next = PH_HDR0;
                end
            endcase
        end

        // End of the length field: range check
        too_big = len_high || (len_val > max_payload_reg) || ((len_val & ~LEN_FIT_MASK) != 32'd0);
        if (len_check)
        begin
            remaining_next = len_val;
            if (too_big)
            begin
                res_valid      = 1'b1;
                res.kind       = KIND_CLOSE;
                res.last       = 1'b1;
                res.close_code = CODE_BIG;
                closed_next    = 1'b1;
            end
            else
            begin
                phase_next    = PH_MASK;
                mask_key_next = 32'd0;
                mask_idx_next = 2'd0;
            end
        end

        // One payload position (or the empty-frame marker)
        di_last = di_end && final_reg;
        if (di_go)
        begin
            if (msg_op_reg == OP_CLOSE)
            begin
                if (di_has && (reason_seen_reg < 2'd2))
                begin
                    peer_reason_next = {peer_reason_reg[7:0], di_byte};
                    reason_seen_next = reason_seen_reg + 2'd1;
                end
                if (di_last)
                begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_CLOSE;
                    res.last       = 1'b1;
                    res.close_code = (reason_seen_next == 2'd2) ? peer_reason_next
                                                                : CODE_NORMAL;
                    closed_next    = 1'b1;
                end
            end
            else if ((msg_op_reg != OP_PONG) && (di_has || di_last))
            begin
                res_valid        = 1'b1;
                res.has_data     = di_has;
                res.payload_byte = di_byte;
                res.last         = di_last;
                if (msg_op_reg > OP_LAST_DATA)
                begin
                    res.kind = (msg_op_reg == OP_PING) ? KIND_PING : KIND_CTRL;
                end
                else
                begin
                    res.kind = binary_reg ? KIND_BINARY : KIND_TEXT;
                end
            end
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (max_payload_we)
        begin
            max_payload_reg <= max_payload_wdata;
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HDR0;
            final_reg       <= 1'b0;
            msg_op_reg      <= OP_CONT;
            binary_reg      <= 1'b0;
            len_count_reg   <= 4'd0;
            remaining_reg   <= 32'd0;
            len_high_reg    <= 1'b0;
            mask_key_reg    <= 32'd0;
            mask_idx_reg    <= 2'd0;
            peer_reason_reg <= 16'd0;
            reason_seen_reg <= 2'd0;
            closed_reg      <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            final_reg       <= final_next;
            msg_op_reg      <= msg_op_next;
            binary_reg      <= binary_next;
            len_count_reg   <= len_count_next;
            remaining_reg   <= remaining_next;
            len_high_reg    <= len_high_next;
            mask_key_reg    <= mask_key_next;
            mask_idx_reg    <= mask_idx_next;
            peer_reason_reg <= peer_reason_next;
            reason_seen_reg <= reason_seen_next;
            closed_reg      <= closed_next;
        end
    end

endmodule

FILE: src/wsfr_out_stage.sv
// Result register: holds one result until the downstream side takes it.
module wsfr_out_stage
    import wsfr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  wsfr_result_t  res,
    output logic          free,
    wsfr_result_if.source result
);

    logic         valid_reg;
    logic         valid_next;
    wsfr_result_t data_reg;

    // Slot can refill in the same cycle it drains
    assign free = !valid_reg || result.ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign result.valid        = valid_reg;
    assign result.kind         = data_reg.kind;
    assign result.has_data     = data_reg.has_data;
    assign result.payload_byte = data_reg.payload_byte;
    assign result.last         = data_reg.last;
    assign result.frame_opcode = data_reg.frame_opcode;
    assign result.close_code   = data_reg.close_code;

endmodule

FILE: src/websocket_frame_receiver_core.sv
// Top level of the WebSocket frame receiver.
// Receives the client-to-server WebSocket byte stream after the upgrade, one byte per
// request on rx, parses each frame header (FIN, opcode, mask bit, 7/16/64-bit length),
// unmasks the payload and emits at most one result per byte on result: text, binary,
// ping and other control bytes, an empty-frame marker, or a close with code 1000, 1002,
// 1009 or the peer's code. After a close every byte is taken and dropped until reset.
// The block takes one byte every cycle while the result side keeps up. An accepted byte
// waits in the input register until the parser pops it and loads any result it yields into
// the result register. While a result waits there, the byte in the input register is held,
// and rx.ready drops once that register is full. The path that sets the clock is the
// 32-bit length decrement and the length-versus-max_payload compare in the parser. The
// user writes max_payload through max_payload_we/max_payload_wdata only while no request
// is in flight; the block itself does not enforce this.
module websocket_frame_receiver_core
    import wsfr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          max_payload_we,
    input  logic [31:0]   max_payload_wdata,
    wsfr_byte_if.sink     rx,
    wsfr_result_if.source result
);

    wsfr_stage_t  stage;
    wsfr_result_t res;
    logic         pop;
    logic         res_valid;
    logic         out_free;

    // Input register
    wsfr_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .pop   (pop),
        .stage (stage)
    );

    // Header parse and unmasking
    wsfr_parser u_parser (
        .clk               (clk),
        .rst_n             (rst_n),
        .max_payload_we    (max_payload_we),
        .max_payload_wdata (max_payload_wdata),
        .stage             (stage),
        .out_free          (out_free),
        .pop               (pop),
        .res_valid         (res_valid),
        .res               (res)
    );

    // Result register
    wsfr_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (res_valid),
        .res    (res),
        .free   (out_free),
        .result (result)
    );

endmodule

FILE: tb/tb_websocket_frame_receiver_core.sv
// Self-checking testbench for the WebSocket frame receiver core.
`timescale 1ns / 1ps

module tb_websocket_frame_receiver_core
    import wsfr_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 4;

    // Opcodes the package does not name
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_RSVD_CTRL_LO = 4'hB;
    localparam logic [3:0] OP_RSVD_CTRL_HI = 4'hF;

    // Length encodings on the wire
    localparam int ENC_SHORT = 0;
    localparam int ENC_16 = 1;
    localparam int ENC_64 = 2;

    typedef enum logic [2:0] {PS_HDR0, PS_HDR1, PS_EXT, PS_MASK, PS_DATA} parse_state_t;

    logic clk;
    logic rst_n;
    logic max_payload_we;
    logic [31:0] max_payload_wdata;

    wsfr_byte_if rx_ch ();
    wsfr_result_if res_ch ();

    websocket_frame_receiver_core DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .max_payload_we    (max_payload_we),
        .max_payload_wdata (max_payload_wdata),
        .rx                (rx_ch),
        .result            (res_ch)
    );

    // Stimulus bytes waiting for the driver, decoded results waiting for the DUT
    logic [7:0] tx_bytes[$];
    wsfr_result_t decoded_items[$];
    int bytes_queued = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cfg_max_int = 0;
    logic rx_taken = 1'b0;

    // Decoder state
    logic [31:0] m_max = MAX_PAYLOAD_RESET;
    parse_state_t m_state = PS_HDR0;
    logic m_fin = 1'b0;
    logic [3:0] m_opcode = OP_CONT;
    logic m_binary = 1'b0;
    logic [3:0] m_ext_left = 4'd0;
    logic [63:0] m_remaining = 64'd0;
    logic [31:0] m_key = 32'd0;
    logic [1:0] m_mask_idx = 2'd0;
    logic [15:0] m_reason = 16'd0;
    logic [1:0] m_reason_cnt = 2'd0;
    logic m_closed = 1'b0;

    // Opening frames: continuation right after reset, empty final binary,
    // ping with 16-bit length, empty pong with RSV bits set
    logic [7:0] opening_bytes [28] = '{
        8'h80, 8'h81, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'h82, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h89, 8'hFE, 8'h00, 8'h01, 8'h12, 8'h34, 8'h56, 8'h78, 8'hED,
        8'hFA, 8'h80, 8'hAA, 8'h55, 8'h0F, 8'hF0
    };

    function automatic string result_text(input wsfr_result_t r);
        return $sformatf("kind=%0d has=%0d byte=%02h last=%0d op=%0h code=%0d",
                         r.kind, r.has_data, r.payload_byte, r.last, r.frame_opcode,
                         r.close_code);
    endfunction

    task automatic close_out(input logic [15:0] code);
        wsfr_result_t r;
        r.kind = KIND_CLOSE;
        r.has_data = 1'b0;
        r.payload_byte = 8'd0;
        r.last = 1'b1;
        r.frame_opcode = m_opcode;
        r.close_code = code;
        decoded_items = {decoded_items, r};
        m_closed = 1'b1;
    endtask

    // One payload position of the current frame
    task automatic payload_pos(input logic has, input logic [7:0] b, input logic at_end);
        logic lastflag;
        wsfr_result_t r;
        lastflag = at_end && m_fin;
        if (m_opcode == OP_CLOSE)
        begin
            // close payload feeds the reason code only
            if (has && m_reason_cnt < 2'd2)
            begin
                m_reason = {m_reason[7:0], b};
                m_reason_cnt = m_reason_cnt + 2'd1;
            end
            if (lastflag)
                close_out((m_reason_cnt >= 2'd2) ? m_reason : CODE_NORMAL);
            return;
        end
        if (m_opcode == OP_PONG)
            return;
        if (!has && !lastflag)
            return;
        if (m_opcode > OP_LAST_DATA)
            r.kind = (m_opcode == OP_PING) ? KIND_PING : KIND_CTRL;
        else
            r.kind = m_binary ? KIND_BINARY : KIND_TEXT;
        r.has_data = has;
        r.payload_byte = b;
        r.last = lastflag;
        r.frame_opcode = m_opcode;
        r.close_code = 16'd0;
        decoded_items = {decoded_items, r};
    endtask

    task automatic check_length();
        if (m_remaining > {32'd0, m_max} || (m_remaining >> LENGTH_BITS) != 64'd0)
        begin
            close_out(CODE_BIG);
        end
        else
        begin
            m_state = PS_MASK;
            m_key = 32'd0;
            m_mask_idx = 2'd0;
        end
    endtask

    // Decode one accepted byte and queue what it produces
    task automatic decode_byte(input logic [7:0] b);
        logic [7:0] plain;
        if (m_closed)
            return;
        case (m_state)
            PS_HDR0:
            begin
                m_fin = b[7];
                if (b[3:0] != OP_CONT)
                begin
                    m_opcode = b[3:0];
                    m_binary = (b[3:0] != OP_TEXT);
                    m_reason = 16'd0;
                    m_reason_cnt = 2'd0;
                end
                m_state = PS_HDR1;
            end
            PS_HDR1:
            begin
                m_remaining = 64'd0;
                if (!b[7])
                begin
                    close_out(CODE_PROTO);
                end
                else if (b[6:0] == LEN7_EXT16)
                begin
                    m_ext_left = EXT16_BYTES;
                    m_state = PS_EXT;
                end
                else if (b[6:0] == LEN7_EXT64)
                begin
                    m_ext_left = EXT64_BYTES;
                    m_state = PS_EXT;
                end
                else
                begin
                    m_ext_left = 4'd0;
                    m_remaining = {57'd0, b[6:0]};
                    check_length();
                end
            end
            PS_EXT:
            begin
                m_remaining = {m_remaining[55:0], b};
                if (m_ext_left != 4'd0)
                    m_ext_left = m_ext_left - 4'd1;
                if (m_ext_left == 4'd0)
                    check_length();
            end
            PS_MASK:
            begin
                m_key = {m_key[23:0], b};
                m_mask_idx = m_mask_idx + 2'd1;
                if (m_mask_idx == 2'd0)
                begin
                    if (m_remaining == 64'd0)
                    begin
                        m_state = PS_HDR0;
                        payload_pos(1'b0, 8'd0, 1'b1);
                    end
                    else
                    begin
                        m_state = PS_DATA;
                    end
                end
            end
            PS_DATA:
            begin
                plain = b ^ m_key[8 * (3 - m_mask_idx) +: 8];
                m_mask_idx = m_mask_idx + 2'd1;
                m_remaining = m_remaining - 64'd1;
                if (m_remaining == 64'd0)
                    m_state = PS_HDR0;
                payload_pos(1'b1, plain, m_remaining == 64'd0);
            end
            default:
            begin
                m_state = PS_HDR0;
            end
        endcase
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Timeout
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Byte driver: a request holds until taken
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rx_ch.valid <= 1'b0;
        end
        else if (!rx_ch.valid || rx_taken)
        begin
            if (tx_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                rx_ch.rx_byte <= tx_bytes.pop_front();
                rx_ch.valid <= 1'b1;
            end
            else
            begin
                rx_ch.valid <= 1'b0;
            end
        end
    end

    // Result backpressure
    always @(negedge clk)
    begin
        res_ch.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor: check results, track register writes, decode taken bytes
    always @(posedge clk)
    begin
        wsfr_result_t got;
        wsfr_result_t want;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got.kind = res_ch.kind;
                got.has_data = res_ch.has_data;
                got.payload_byte = res_ch.payload_byte;
                got.last = res_ch.last;
                got.frame_opcode = res_ch.frame_opcode;
                got.close_code = res_ch.close_code;
                if (decoded_items.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected result: %s", result_text(got));
                    mismatch_count++;
                end
                else
                begin
                    want = decoded_items.pop_front();
                    if (got.kind !== want.kind || got.has_data !== want.has_data ||
                        got.payload_byte !== want.payload_byte || got.last !== want.last ||
                        got.frame_opcode !== want.frame_opcode ||
                        got.close_code !== want.close_code)
                    begin
                        if (mismatch_count < 10)
                            $display("result mismatch: expected %s, got %s",
                                     result_text(want), result_text(got));
                        mismatch_count++;
                    end
                end
            end
            if (max_payload_we)
                m_max = max_payload_wdata;
            if (rx_ch.valid && rx_ch.ready)
                decode_byte(rx_ch.rx_byte);
        end
        rx_taken <= rst_n && rx_ch.valid && rx_ch.ready;
    end

    task automatic push_byte(input logic [7:0] b);
        tx_bytes = {tx_bytes, b};
        bytes_queued++;
    endtask

    // Header bytes up to and including the extended length
    task automatic queue_header(input logic fin, input logic [3:0] op, input logic mask,
                                input int enc, input logic [63:0] len);
        push_byte({fin, 3'($urandom), op});
        case (enc)
            ENC_SHORT:
            begin
                push_byte({mask, len[6:0]});
            end
            ENC_16:
            begin
                push_byte({mask, LEN7_EXT16});
                push_byte(len[15:8]);
                push_byte(len[7:0]);
            end
            default:
            begin
                push_byte({mask, LEN7_EXT64});
                for (int i = 7; i >= 0; i--)
                    push_byte(len[8 * i +: 8]);
            end
        endcase
    endtask

    // Well-formed masked frame with random key and payload
    task automatic queue_frame(input logic fin, input logic [3:0] op, input int len);
        int enc;
        logic [31:0] key;
        if (len >= 126)
            enc = $urandom_range(ENC_16, ENC_64);
        else
            enc = ($urandom_range(0, 9) < 7) ? ENC_SHORT : $urandom_range(ENC_16, ENC_64);
        key = $urandom;
        queue_header(fin, op, 1'b1, enc, 64'(len));
        for (int i = 3; i >= 0; i--)
            push_byte(key[8 * i +: 8]);
        repeat (len) push_byte(8'($urandom));
    endtask

    function automatic int pick_len(input int limit);
        int r;
        int len;
        r = $urandom_range(0, 9);
        if (r == 0)
            len = 0;
        else if (r < 7)
            len = $urandom_range(1, 6);
        else if (r < 9)
            len = $urandom_range(7, 20);
        else
            len = $urandom_range(100, 140);
        return (len > limit) ? limit : len;
    endfunction

    function automatic logic [3:0] pick_ctrl_op();
        case ($urandom_range(0, 3))
            0: return OP_PING;
            1: return OP_PONG;
            default: return 4'($urandom_range(OP_RSVD_CTRL_LO, OP_RSVD_CTRL_HI));
        endcase
    endfunction

    // Mixed traffic: fragmented messages with interleaved control frames,
    // standalone control frames and stray continuations; never a close
    task automatic random_traffic(input int budget, input int limit);
        int start;
        int frames;
        int ctl_limit;
        logic [3:0] op;
        start = bytes_queued;
        ctl_limit = (limit > 125) ? 125 : limit;
        while (bytes_queued - start < budget)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    if ($urandom_range(0, 9) < 5)
                        op = OP_TEXT;
                    else
                        op = 4'($urandom_range(OP_BINARY, OP_LAST_DATA));
                    frames = $urandom_range(1, 3);
                    for (int f = 0; f < frames; f++)
                    begin
                        queue_frame(f == frames - 1, (f == 0) ? op : OP_CONT, pick_len(limit));
                        if (f < frames - 1 && $urandom_range(0, 3) == 0)
                            queue_frame(1'b1, pick_ctrl_op(), pick_len(ctl_limit));
                    end
                end
                6, 7, 8:
                begin
                    queue_frame($urandom_range(0, 4) != 0, pick_ctrl_op(), pick_len(ctl_limit));
                end
                default:
                begin
                    queue_frame(1'($urandom), OP_CONT, pick_len(limit));
                end
            endcase
        end
    endtask

    // Wait until every request is taken and every result has come out
    task automatic drain();
        while (tx_bytes.size() != 0 || rx_ch.valid || decoded_items.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max(input logic [31:0] value);
        @(negedge clk);
        max_payload_we <= 1'b1;
        max_payload_wdata <= value;
        @(negedge clk);
        max_payload_we <= 1'b0;
        cfg_max_int = (value > 32'd300) ? 300 : int'(value);
    endtask

    // Stimulus sequence
    initial
    begin
        logic [3:0] op;
        rst_n = 1'b0;
        max_payload_we = 1'b0;
        max_payload_wdata = 32'd0;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = 8'd0;
        res_ch.ready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed opening frames at the reset limit
        send_idle_pct = 38;
        recv_idle_pct = 69;
        foreach (opening_bytes[i])
            push_byte(opening_bytes[i]);
        drain();

        // widest limit
        write_max(32'hFFFF_FFFF);
        random_traffic(250, cfg_max_int);
        drain();

        // tight limit, idling swapped
        @(posedge clk);
        send_idle_pct = 69;
        recv_idle_pct = 38;
        write_max($urandom_range(8, 40));
        random_traffic(240, cfg_max_int);
        drain();

        // zero limit: only empty frames get through
        @(posedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_max(32'd0);
        repeat (8)
        begin
            do op = 4'($urandom); while (op == OP_CLOSE);
            queue_frame(1'($urandom), op, 0);
        end
        drain();

        // limit that admits 16-bit lengths
        write_max($urandom_range(130, 300));
        random_traffic(190, cfg_max_int);
        drain();

        // one terminating event, then bytes that must be ignored
        case ($urandom_range(0, 4))
            0:
            begin
                // peer reason code, possibly split over a continuation
                if ($urandom_range(0, 1))
                begin
                    queue_frame(1'b1, OP_CLOSE, $urandom_range(2, 10));
                end
                else
                begin
                    queue_frame(1'b0, OP_CLOSE, 1);
                    queue_frame(1'b1, OP_CONT, $urandom_range(1, 5));
                end
            end
            1:
            begin
                // close with fewer than two payload bytes
                queue_frame(1'b1, OP_CLOSE, $urandom_range(0, 1));
            end
            2:
            begin
                // mask bit clear
                do op = 4'($urandom); while (op == OP_CLOSE);
                queue_header(1'($urandom), op, 1'b0, ENC_SHORT, 64'($urandom_range(0, 125)));
            end
            3:
            begin
                // length just above the limit
                write_max($urandom_range(0, 60));
                queue_header(1'b1, OP_BINARY, 1'b1, $urandom_range(ENC_SHORT, ENC_64),
                             64'(cfg_max_int + $urandom_range(1, 3)));
            end
            default:
            begin
                // 64-bit length beyond any 32-bit limit
                write_max(32'hFFFF_FFFF);
                queue_header(1'b1, OP_TEXT, 1'b1, ENC_64,
                             {32'($urandom) | 32'd1, 32'($urandom)});
            end
        endcase
        repeat (20) push_byte(8'($urandom));
        drain();

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
src/wsfr_pkg.sv
src/wsfr_if.sv
src/wsfr_in_stage.sv
src/wsfr_parser.sv
src/wsfr_out_stage.sv
src/websocket_frame_receiver_core.sv
tb/tb_websocket_frame_receiver_core.sv
